@@ hdl/fssp_pkg.sv @@
// shared types and constants for the flash script stream parser
// no dependencies; imported by every module of the block
package fssp_pkg;

  localparam int MAX_LINE_CHARS = 400;
  localparam int MAX_DATA       = 128;

  localparam int LP_W = $clog2(MAX_LINE_CHARS + 1);
  localparam int PI_W = $clog2(MAX_DATA + 2);

  localparam int FIFO_DEPTH = 4;
  localparam int FIFO_AW    = $clog2(FIFO_DEPTH);
  localparam int FIFO_CW    = $clog2(FIFO_DEPTH + 1);

  localparam logic [7:0] CH_CR    = 8'h0D;
  localparam logic [7:0] CH_LF    = 8'h0A;
  localparam logic [7:0] CH_SPACE = 8'h20;
  localparam logic [7:0] CH_COLON = 8'h3A;
  localparam logic [7:0] CH_W     = 8'h57;
  localparam logic [7:0] CH_C     = 8'h43;
  localparam logic [7:0] CH_R     = 8'h52;
  localparam logic [7:0] CH_X     = 8'h58;

  typedef enum logic [2:0] {
    KIND_WRITE   = 3'd0,
    KIND_COMPARE = 3'd1,
    KIND_READ    = 3'd2,
    KIND_DELAY   = 3'd3,
    KIND_STOP    = 3'd4
  } kind_t;

  typedef struct packed {
    kind_t       kind;
    logic [7:0]  dev;
    logic [7:0]  reg_a;
    logic [15:0] value;
    logic        last;
    logic        ovf;
  } rec_t;

endpackage

@@ hdl/fssp_core.sv @@
// per-byte line parser: line state registers and the single-pass next-state logic
// depends on fssp_pkg; emits up to two records per byte to the result queue
module fssp_core (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              go_i,
  input  logic [7:0]        char_i,
  input  logic              fs_i,
  input  logic              fe_i,
  output fssp_pkg::rec_t    rec_a_o,
  output fssp_pkg::rec_t    rec_b_o,
  output logic [1:0]        push_n_o
);
  import fssp_pkg::*;

  logic [LP_W-1:0] line_pos_r, line_pos_nxt;
  logic [LP_W-1:0] kept_r, kept_nxt;
  logic [7:0]      letter_r, letter_nxt;
  logic            colon_r, colon_nxt;
  logic [4:0]      hi_r, hi_nxt;
  logic [PI_W-1:0] pi_r, pi_nxt;
  logic [7:0]      dev_r, dev_nxt;
  logic [7:0]      base_r, base_nxt;
  logic [8:0]      held_r, held_nxt;
  logic [16:0]     dec_r, dec_nxt;
  logic            stopped_r, stopped_nxt;

  logic            crlf, ends, is_wc, hex_en, dec_en;
  logic [LP_W-1:0] lp_inc, k;
  logic [4:0]      hv;
  logic [7:0]      pair_b, rd_dev, rd_reg;
  logic [19:0]     dec_v;
  logic            r0v, r1v;
  rec_t            r0, r1;

  // bit 4 set when the character is a hex digit
  function automatic logic [4:0] hex_of(input logic [7:0] c);
    logic [4:0] h;
    h = 5'h00;
    if (c >= 8'h30 && c <= 8'h39) h = {1'b1, 4'(c - 8'h30)};
    else if (c >= 8'h41 && c <= 8'h46) h = {1'b1, 4'(c - 8'h37)};
    else if (c >= 8'h61 && c <= 8'h66) h = {1'b1, 4'(c - 8'h57)};
    return h;
  endfunction

  function automatic logic [7:0] held_reg(input logic [7:0] base, input logic [PI_W-1:0] pi);
    logic [PI_W-1:0] cnt;
    cnt = (pi > PI_W'(MAX_DATA)) ? PI_W'(MAX_DATA) : pi;
    return base + cnt[7:0] - 8'd1;
  endfunction

  function automatic rec_t mk_rec(input kind_t kind, input logic [7:0] dev,
                                  input logic [7:0] reg_a, input logic [15:0] value,
                                  input logic last, input logic ovf);
    rec_t r;
    r.kind  = kind;
    r.dev   = dev;
    r.reg_a = reg_a;
    r.value = value;
    r.last  = last;
    r.ovf   = ovf;
    return r;
  endfunction

  always_comb begin
    // file start clears everything before the byte is used
    line_pos_nxt = fs_i ? '0 : line_pos_r;
    kept_nxt     = fs_i ? '0 : kept_r;
    letter_nxt   = fs_i ? 8'h00 : letter_r;
    colon_nxt    = fs_i ? 1'b0 : colon_r;
    hi_nxt       = fs_i ? 5'h00 : hi_r;
    pi_nxt       = fs_i ? '0 : pi_r;
    dev_nxt      = fs_i ? 8'h00 : dev_r;
    base_nxt     = fs_i ? 8'h00 : base_r;
    held_nxt     = fs_i ? 9'h000 : held_r;
    dec_nxt      = fs_i ? 17'h00000 : dec_r;
    stopped_nxt  = fs_i ? 1'b0 : stopped_r;

    crlf   = (char_i == CH_CR) || (char_i == CH_LF);
    ends   = 1'b0;
    lp_inc = line_pos_nxt + LP_W'(1);
    k      = kept_nxt;
    is_wc  = 1'b0;
    hex_en = 1'b0;
    dec_en = 1'b0;
    hv     = hex_of(char_i);
    pair_b = 8'h00;
    rd_dev = 8'h00;
    rd_reg = 8'h00;
    dec_v  = 20'h00000;
    r0v    = 1'b0;
    r1v    = 1'b0;
    r0     = '0;
    r1     = '0;

    if (!stopped_nxt && !(line_pos_nxt == '0 && crlf)) begin
      line_pos_nxt = lp_inc;
      ends = crlf || fe_i || (lp_inc >= LP_W'(MAX_LINE_CHARS));

      if (!crlf && char_i != CH_SPACE) begin
        kept_nxt = k + LP_W'(1);
        if (k == LP_W'(0)) begin
          letter_nxt = char_i;
        end else if (k == LP_W'(1)) begin
          colon_nxt = (char_i == CH_COLON);
        end else if (colon_nxt) begin
          is_wc  = (letter_nxt == CH_W) || (letter_nxt == CH_C);
          hex_en = is_wc || (letter_nxt == CH_R && k < LP_W'(6));
          dec_en = (letter_nxt == CH_R && k >= LP_W'(6)) || (letter_nxt == CH_X);
          if (hex_en) begin
            if (!k[0]) begin
              hi_nxt = hv;
            end else begin
              if (hi_nxt[4]) pair_b = hv[4] ? {hi_nxt[3:0], hv[3:0]} : {4'h0, hi_nxt[3:0]};
              if (k < LP_W'(4)) begin
                dev_nxt = pair_b;
              end else if (k < LP_W'(6)) begin
                base_nxt = pair_b;
              end else if (pi_nxt < PI_W'(MAX_DATA)) begin
                // previous byte goes out now that it is known not to be last
                if (held_nxt[8]) begin
                  r0v = 1'b1;
                  r0  = mk_rec(letter_nxt == CH_W ? KIND_WRITE : KIND_COMPARE, dev_nxt,
                               held_reg(base_nxt, pi_nxt), {8'h00, held_nxt[7:0]},
                               1'b0, 1'b0);
                end
                held_nxt = {1'b1, pair_b};
                pi_nxt   = pi_nxt + PI_W'(1);
              end else begin
                pi_nxt = PI_W'(MAX_DATA + 1);
              end
            end
          end
          if (dec_en && !dec_nxt[16]) begin
            if (char_i >= 8'h30 && char_i <= 8'h39) begin
              dec_v = {dec_nxt[15:0], 3'b000} + {3'b000, dec_nxt[15:0], 1'b0}
                      + {12'h000, char_i - 8'h30};
              dec_nxt = (dec_v > 20'h0FFFF) ? 17'h0FFFF : {1'b0, dec_v[15:0]};
            end else begin
              dec_nxt[16] = 1'b1;
            end
          end
        end
      end

      if (ends) begin
        if (colon_nxt) begin
          if (letter_nxt == CH_W || letter_nxt == CH_C) begin
            if (held_nxt[8]) begin
              r1v = 1'b1;
              r1  = mk_rec(letter_nxt == CH_W ? KIND_WRITE : KIND_COMPARE, dev_nxt,
                           held_reg(base_nxt, pi_nxt), {8'h00, held_nxt[7:0]},
                           1'b1, pi_nxt > PI_W'(MAX_DATA));
            end
          end else if (letter_nxt == CH_R) begin
            // a lone digit in the address or register pair stands alone
            rd_dev = (kept_nxt == LP_W'(3)) ? {4'h0, hi_nxt[3:0]} : dev_nxt;
            rd_reg = (kept_nxt == LP_W'(5)) ? {4'h0, hi_nxt[3:0]} : base_nxt;
            r1v = 1'b1;
            r1  = mk_rec(KIND_READ, rd_dev, rd_reg, dec_nxt[15:0], 1'b1, 1'b0);
          end else if (letter_nxt == CH_X) begin
            r1v = 1'b1;
            r1  = mk_rec(KIND_DELAY, 8'h00, 8'h00, dec_nxt[15:0], 1'b1, 1'b0);
          end else begin
            r1v = 1'b1;
            r1  = mk_rec(KIND_STOP, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0);
            stopped_nxt = 1'b1;
          end
        end
        line_pos_nxt = '0;
        kept_nxt     = '0;
        letter_nxt   = 8'h00;
        colon_nxt    = 1'b0;
        hi_nxt       = 5'h00;
        pi_nxt       = '0;
        dev_nxt      = 8'h00;
        base_nxt     = 8'h00;
        held_nxt     = 9'h000;
        dec_nxt      = 17'h00000;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      line_pos_r <= '0;
      kept_r     <= '0;
      letter_r   <= 8'h00;
      colon_r    <= 1'b0;
      hi_r       <= 5'h00;
      pi_r       <= '0;
      dev_r      <= 8'h00;
      base_r     <= 8'h00;
      held_r     <= 9'h000;
      dec_r      <= 17'h00000;
      stopped_r  <= 1'b0;
    end else if (go_i) begin
      line_pos_r <= line_pos_nxt;
      kept_r     <= kept_nxt;
      letter_r   <= letter_nxt;
      colon_r    <= colon_nxt;
      hi_r       <= hi_nxt;
      pi_r       <= pi_nxt;
      dev_r      <= dev_nxt;
      base_r     <= base_nxt;
      held_r     <= held_nxt;
      dec_r      <= dec_nxt;
      stopped_r  <= stopped_nxt;
    end
  end

  // compact so the first queued record is always slot a
  assign rec_a_o  = r0v ? r0 : r1;
  assign rec_b_o  = r1;
  assign push_n_o = go_i ? ({1'b0, r0v} + {1'b0, r1v}) : 2'd0;

  a_stopped_silent: assert property (@(posedge clk) disable iff (!rst_n)
    go_i && stopped_r && !fs_i |-> push_n_o == 2'd0)
    else $error("record pushed while stopped");

  a_pair_order: assert property (@(posedge clk) disable iff (!rst_n)
    push_n_o == 2'd2 |-> rec_b_o.last && !rec_a_o.last)
    else $error("two records without last on the second only");

  a_blank_start: assert property (@(posedge clk) disable iff (!rst_n)
    go_i && (fs_i || line_pos_r == '0) && crlf |-> push_n_o == 2'd0)
    else $error("record from cr/lf at line start");

endmodule

@@ hdl/fssp_fifo.sv @@
// small result queue: up to two records in, one out per cycle while ready_i
// depends on fssp_pkg for the record type and depth
module fssp_fifo (
  input  logic              clk,
  input  logic              rst_n,
  input  fssp_pkg::rec_t    rec_a_i,
  input  fssp_pkg::rec_t    rec_b_i,
  input  logic [1:0]        push_n_i,
  output logic              space_o,
  output fssp_pkg::rec_t    rec_o,
  output logic              valid_o,
  input  logic              ready_i
);
  import fssp_pkg::*;

  rec_t               mem_r [FIFO_DEPTH];
  logic [FIFO_AW-1:0] wr_r, wr_nxt, wr_p1;
  logic [FIFO_AW-1:0] rd_r, rd_nxt;
  logic [FIFO_CW-1:0] cnt_r, cnt_nxt;
  logic               pop;

  assign pop     = valid_o && ready_i;
  assign wr_p1   = wr_r + FIFO_AW'(1);
  assign wr_nxt  = wr_r + FIFO_AW'(push_n_i);
  assign rd_nxt  = pop ? rd_r + FIFO_AW'(1) : rd_r;
  assign cnt_nxt = cnt_r + FIFO_CW'(push_n_i) - FIFO_CW'(pop);
  assign valid_o = (cnt_r != '0);
  assign rec_o   = mem_r[rd_r];
  // room for the worst case of two records from one beat
  assign space_o = (cnt_r <= FIFO_CW'(FIFO_DEPTH - 2));

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_r  <= '0;
      rd_r  <= '0;
      cnt_r <= '0;
    end else begin
      wr_r  <= wr_nxt;
      rd_r  <= rd_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push_n_i != 2'd0) mem_r[wr_r] <= rec_a_i;
    if (push_n_i == 2'd2) mem_r[wr_p1] <= rec_b_i;
  end

  a_cnt_bound: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= FIFO_CW'(FIFO_DEPTH))
    else $error("queue count beyond depth");

  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    push_n_i != 2'd0 |-> space_o)
    else $error("push without room");

  a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r != FIFO_CW'(FIFO_DEPTH) |-> FIFO_AW'(wr_r - rd_r) == FIFO_AW'(cnt_r))
    else $error("pointers disagree with count");

endmodule

@@ hdl/flash_stream_script_parser_unit.sv @@
// flash script stream parser top level: input beat register, line parser, result queue
// path: an accepted beat is held in the input beat register, and its records
// are written into the result queue, which drives the output
// throughput: one input beat per cycle while the result queue has room; a beat that
// closes a data line can give two records, which leave the queue one after the other
// reset: synchronous active-low rst_n clears the line state, stop flag and queue
// depends on fssp_pkg, fssp_core and fssp_fifo
module flash_stream_script_parser_unit (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] char_in
  input  logic        in_tuser,   // [0] file_start
  input  logic        in_tlast,   // file_end
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [7:0] device_addr, [15:8] reg_addr,
                                  // [31:16] value, [32] overflow, rest zero
  output logic [2:0]  out_tuser,  // [2:0] cmd_kind
  output logic        out_tlast   // last_of_cmd
);
  import fssp_pkg::*;

  logic       item_vld_r, item_vld_nxt;
  logic [7:0] item_char_r;
  logic       item_fs_r;
  logic       item_fe_r;
  logic       go, space, in_acc;
  rec_t       rec_a, rec_b, rec_out;
  logic [1:0] push_n;

  assign go        = item_vld_r && space;
  assign in_tready = !item_vld_r || go;
  assign in_acc    = in_tvalid && in_tready;

  always_comb begin
    item_vld_nxt = item_vld_r;
    if (in_acc) item_vld_nxt = 1'b1;
    else if (go) item_vld_nxt = 1'b0;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      item_vld_r <= 1'b0;
    end else begin
      item_vld_r <= item_vld_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      item_char_r <= in_tdata;
      item_fs_r   <= in_tuser;
      item_fe_r   <= in_tlast;
    end
  end

  fssp_core u_core (
    .clk      (clk),
    .rst_n    (rst_n),
    .go_i     (go),
    .char_i   (item_char_r),
    .fs_i     (item_fs_r),
    .fe_i     (item_fe_r),
    .rec_a_o  (rec_a),
    .rec_b_o  (rec_b),
    .push_n_o (push_n)
  );

  fssp_fifo u_fifo (
    .clk      (clk),
    .rst_n    (rst_n),
    .rec_a_i  (rec_a),
    .rec_b_i  (rec_b),
    .push_n_i (push_n),
    .space_o  (space),
    .rec_o    (rec_out),
    .valid_o  (out_tvalid),
    .ready_i  (out_tready)
  );

  assign out_tdata = {7'h00, rec_out.ovf, rec_out.value, rec_out.reg_a, rec_out.dev};
  assign out_tuser = rec_out.kind;
  assign out_tlast = rec_out.last;

endmodule

@@ tb/testbench.sv @@
`timescale 1ns / 100ps
// self-checking bench for flash_stream_script_parser_unit: feeds script bytes,
// mirrors the line parser in behavioural code and checks each record in order
// depends on fssp_pkg and the flash_stream_script_parser_unit rtl
module testbench;
  import fssp_pkg::*;

  localparam int CYCLE_LIMIT  = 500000;
  localparam int RANDOM_BEATS = 350;
  localparam int TAIL_BEATS   = 150;
  localparam int HOLD_CYCLES  = 80;
  localparam int SETTLE       = 8;

  typedef enum int {TERM_LF, TERM_CR, TERM_CRLF, TERM_NONE} line_term_t;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        in_tvalid = 1'b0;
  logic        in_tready;
  logic [7:0]  in_tdata = 8'h00;
  logic        in_tuser = 1'b0;
  logic        in_tlast = 1'b0;
  logic        out_tvalid;
  logic        out_tready = 1'b0;
  logic [39:0] out_tdata;
  logic [2:0]  out_tuser;
  logic        out_tlast;

  int unsigned cycle_count = 0;
  int unsigned errors = 0;
  int unsigned live_beats = 0;
  bit          quiet = 1'b0;
  logic        hold_on = 1'b0;
  int          stall_left = 0;

  rec_t        pending_records[$];
  logic [7:0]  script[$];

  // mirror of the parser state
  int unsigned col, nkept, nbytes;
  logic [7:0]  letter, dev_q, reg_base;
  bit          has_colon, halted;
  logic [4:0]  first_dig;
  logic [8:0]  pend;
  logic [16:0] num;

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  flash_stream_script_parser_unit dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .in_tlast   (in_tlast),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tuser  (out_tuser),
    .out_tlast  (out_tlast)
  );

  // ---------------------------------------------------------------- parser mirror

  function automatic void clear_line();
    col = 0;
    nkept = 0;
    letter = 8'h00;
    has_colon = 1'b0;
    first_dig = 5'd0;
    nbytes = 0;
    dev_q = 8'h00;
    reg_base = 8'h00;
    pend = 9'h000;
    num = 17'h00000;
  endfunction

  function automatic logic [4:0] hex_digit(logic [7:0] c);
    if (c >= "0" && c <= "9") return 5'(c - "0");
    if (c >= "A" && c <= "F") return 5'(c - "A" + 10);
    if (c >= "a" && c <= "f") return 5'(c - "a" + 10);
    return 5'd16;
  endfunction

  function automatic void emit(kind_t k, logic [7:0] d, logic [7:0] r, logic [15:0] v,
                               logic l, logic o);
    rec_t rec;
    rec.kind = k;
    rec.dev = d;
    rec.reg_a = r;
    rec.value = v;
    rec.last = l;
    rec.ovf = o;
    pending_records.push_back(rec);
  endfunction

  function automatic kind_t data_kind();
    return (letter == CH_W) ? KIND_WRITE : KIND_COMPARE;
  endfunction

  // register address of the byte currently held back
  function automatic logic [7:0] held_reg_addr();
    int unsigned cnt;
    cnt = (nbytes > MAX_DATA) ? MAX_DATA : nbytes;
    return 8'(reg_base + cnt - 1);
  endfunction

  function automatic void dec_step(logic [7:0] c);
    int unsigned v;
    if (num[16]) return;
    if (c >= "0" && c <= "9") begin
      v = num[15:0] * 10 + (c - "0");
      if (v > 65535) v = 65535;
      num = 17'(v);
    end else begin
      num[16] = 1'b1;
    end
  endfunction

  function automatic void hex_step(int unsigned p, logic [7:0] c, bit is_data);
    logic [4:0] v;
    logic [7:0] b;
    v = hex_digit(c);
    if (p % 2 == 0) begin
      first_dig = (v < 16) ? {1'b1, v[3:0]} : 5'd0;
      return;
    end
    if (!first_dig[4]) b = 8'h00;
    else if (v < 16) b = {first_dig[3:0], v[3:0]};
    else b = {4'h0, first_dig[3:0]};
    case (p / 2)
      0: dev_q = b;
      1: reg_base = b;
      default: if (is_data) begin
        if (nbytes < MAX_DATA) begin
          if (pend[8])
            emit(data_kind(), dev_q, held_reg_addr(), {8'h00, pend[7:0]}, 1'b0, 1'b0);
          pend = {1'b1, b};
          nbytes++;
        end else begin
          nbytes = MAX_DATA + 1;
        end
      end
    endcase
  endfunction

  function automatic void finish_line();
    if (has_colon) begin
      if (letter == CH_W || letter == CH_C) begin
        if (pend[8])
          emit(data_kind(), dev_q, held_reg_addr(), {8'h00, pend[7:0]}, 1'b1,
               nbytes > MAX_DATA);
      end else if (letter == CH_R) begin
        // a lone digit in the address or register pair stands on its own
        if (nkept == 3) dev_q = {4'h0, first_dig[3:0]};
        if (nkept == 5) reg_base = {4'h0, first_dig[3:0]};
        emit(KIND_READ, dev_q, reg_base, num[15:0], 1'b1, 1'b0);
      end else if (letter == CH_X) begin
        emit(KIND_DELAY, 8'h00, 8'h00, num[15:0], 1'b1, 1'b0);
      end else begin
        emit(KIND_STOP, 8'h00, 8'h00, 16'h0000, 1'b1, 1'b0);
        halted = 1'b1;
      end
    end
    clear_line();
  endfunction

  function automatic void parse_byte(logic [7:0] c, logic fs, logic fe);
    bit crlf, ends;
    int unsigned k;
    crlf = (c == CH_CR || c == CH_LF);
    if (fs) begin
      clear_line();
      halted = 1'b0;
    end
    if (halted) return;
    if (col == 0 && crlf) return;
    live_beats++;
    col++;
    ends = crlf || fe || col >= MAX_LINE_CHARS;
    if (!crlf && c != CH_SPACE) begin
      k = nkept;
      nkept++;
      if (k == 0) begin
        letter = c;
      end else if (k == 1) begin
        has_colon = (c == CH_COLON);
      end else if (has_colon) begin
        if (letter == CH_W || letter == CH_C) begin
          hex_step(k - 2, c, 1'b1);
        end else if (letter == CH_R) begin
          if (k - 2 < 4) hex_step(k - 2, c, 1'b0);
          else dec_step(c);
        end else if (letter == CH_X) begin
          dec_step(c);
        end
      end
    end
    if (ends) finish_line();
  endfunction

  // ---------------------------------------------------------------- script building

  function automatic void add_str(string s);
    for (int i = 0; i < s.len(); i++) script.push_back(s[i]);
  endfunction

  function automatic void end_line(line_term_t t);
    case (t)
      TERM_LF: script.push_back(CH_LF);
      TERM_CR: script.push_back(CH_CR);
      TERM_CRLF: begin
        script.push_back(CH_CR);
        script.push_back(CH_LF);
      end
      default: ;
    endcase
  endfunction

  function automatic logic [7:0] hex_char(logic [3:0] d);
    if (d < 10) return 8'("0" + d);
    return 8'(($urandom_range(0, 1) ? "A" : "a") + d - 10);
  endfunction

  function automatic void put_hex(logic [7:0] b);
    logic [7:0] hi, lo;
    hi = hex_char(b[7:4]);
    lo = hex_char(b[3:0]);
    // now and then a digit that is not hex at all
    if ($urandom_range(0, 15) == 0) hi = 8'($urandom_range(8'h67, 8'h7a));
    if ($urandom_range(0, 15) == 0) lo = 8'($urandom_range(8'h47, 8'h5a));
    if ($urandom_range(0, 3) == 0) script.push_back(CH_SPACE);
    script.push_back(hi);
    script.push_back(lo);
  endfunction

  function automatic void random_line(bit closing);
    int unsigned pick, count;
    logic [7:0] ltr;
    pick = $urandom_range(0, 99);
    if (pick < 50) begin
      script.push_back(pick < 30 ? CH_W : CH_C);
      script.push_back(CH_COLON);
      put_hex(8'($urandom));
      put_hex(8'($urandom));
      if ($urandom_range(0, 49) == 0) count = $urandom_range(MAX_DATA - 2, MAX_DATA + 4);
      else count = $urandom_range(0, 6);
      repeat (count) put_hex(8'($urandom));
      // lone trailing digit
      if ($urandom_range(0, 7) == 0) script.push_back(hex_char(4'($urandom)));
    end else if (pick < 65) begin
      script.push_back(CH_R);
      script.push_back(CH_COLON);
      case ($urandom_range(0, 5))
        0: ;
        1: script.push_back(hex_char(4'($urandom)));
        2: begin
          put_hex(8'($urandom));
          script.push_back(hex_char(4'($urandom)));
        end
        default: begin
          put_hex(8'($urandom));
          put_hex(8'($urandom));
          if ($urandom_range(0, 1)) script.push_back(CH_SPACE);
          add_str($sformatf("%0d", $urandom_range(0, 99999)));
          if ($urandom_range(0, 5) == 0) add_str("x7");
        end
      endcase
    end else if (pick < 78) begin
      script.push_back(CH_X);
      script.push_back(CH_COLON);
      if ($urandom_range(0, 7) != 0) add_str($sformatf("%0d", $urandom_range(0, 70000)));
      if ($urandom_range(0, 5) == 0) add_str("ms3");
    end else if (pick < 82) begin
      do ltr = 8'($urandom_range(8'h41, 8'h5a));
      while (ltr == CH_W || ltr == CH_C || ltr == CH_R || ltr == CH_X);
      script.push_back(ltr);
      script.push_back(CH_COLON);
      if ($urandom_range(0, 1)) put_hex(8'($urandom));
    end else if (pick < 90) begin
      script.push_back(CH_W);
      repeat ($urandom_range(1, 10)) script.push_back(8'($urandom_range(8'h21, 8'h7e)));
    end else begin
      repeat ($urandom_range(1, 12)) script.push_back(8'($urandom));
    end
    if ($urandom_range(0, 9) == 0) end_line(TERM_LF);
    pick = $urandom_range(0, 99);
    if (closing && pick < 30) end_line(TERM_NONE);
    else if (pick < 55) end_line(TERM_LF);
    else if (pick < 80) end_line(TERM_CRLF);
    else end_line(TERM_CR);
  endfunction

  // ---------------------------------------------------------------- driving

  task automatic send_beat(logic [7:0] ch, logic fs, logic fe);
    if (!quiet && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 4)) @(posedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= ch;
    in_tuser <= fs;
    in_tlast <= fe;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    parse_byte(ch, fs, fe);
  endtask

  task automatic send_script(bit first_start, bit last_end);
    int n;
    n = script.size();
    for (int i = 0; i < n; i++)
      send_beat(script[i], first_start && i == 0, last_end && i == n - 1);
    script.delete();
  endtask

  task automatic wait_drain();
    // stop offering so the last beat is not taken again
    in_tvalid <= 1'b0;
    @(posedge clk);
    while (pending_records.size() != 0) @(posedge clk);
  endtask

  // ---------------------------------------------------------------- checking

  task automatic report_mismatch(string what);
    errors++;
    // keep the log short when everything goes wrong
    if (errors <= 50) $display("mismatch at cycle %0d: %s", cycle_count, what);
  endtask

  task automatic check_record();
    rec_t want;
    if (pending_records.size() == 0) begin
      report_mismatch($sformatf("unexpected record kind %0d data %h", out_tuser, out_tdata));
      return;
    end
    want = pending_records.pop_front();
    if (out_tuser !== want.kind)
      report_mismatch($sformatf("cmd_kind %0d, expected %0d", out_tuser, want.kind));
    if (out_tdata[7:0] !== want.dev)
      report_mismatch($sformatf("device_addr %h, expected %h", out_tdata[7:0], want.dev));
    if (out_tdata[15:8] !== want.reg_a)
      report_mismatch($sformatf("reg_addr %h, expected %h", out_tdata[15:8], want.reg_a));
    if (out_tdata[31:16] !== want.value)
      report_mismatch($sformatf("value %0d, expected %0d", out_tdata[31:16], want.value));
    if (out_tdata[32] !== want.ovf)
      report_mismatch($sformatf("overflow %b, expected %b", out_tdata[32], want.ovf));
    if (out_tlast !== want.last)
      report_mismatch($sformatf("last_of_cmd %b, expected %b", out_tlast, want.last));
    if (out_tdata[39:33] !== 7'h00)
      report_mismatch($sformatf("padding bits %h not zero", out_tdata[39:33]));
  endtask

  always @(posedge clk) begin
    if (!rst_n) begin
      out_tready <= 1'b0;
    end else begin
      if (out_tvalid && out_tready) check_record();
      if (stall_left > 0) stall_left--;
      else if (!quiet && $urandom_range(0, 6) == 0) stall_left = $urandom_range(1, 4);
      out_tready <= !hold_on && stall_left == 0;
    end
  end

  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("flash_stream_script_parser_unit test failed");
      $finish;
    end
  end

  // ---------------------------------------------------------------- tests

  task automatic test_write_compare();
    add_str("W:A0FE00FF7F");            // extreme bytes, register wraps past ff
    end_line(TERM_CRLF);
    add_str("C:1b2a3C");
    end_line(TERM_LF);
    add_str("W: 10 20 g5 3z 44");       // non-hex first digit, non-hex second digit
    end_line(TERM_LF);
    add_str("W:1020304");               // odd trailing digit dropped
    end_line(TERM_LF);
    add_str("W:1020");                  // no data bytes
    end_line(TERM_CR);
    add_str("W:55AA01");                // end of file closes a held byte
    send_script(1'b1, 1'b1);
    wait_drain();
  endtask

  task automatic test_read_delay();
    add_str("R:A010 70000");            // count saturates
    end_line(TERM_LF);
    add_str("R:5");
    end_line(TERM_LF);
    add_str("R:A03");
    end_line(TERM_LF);
    add_str("R:");
    end_line(TERM_LF);
    add_str("R:FF00 12x9");
    end_line(TERM_CR);
    add_str("X:250");
    end_line(TERM_LF);
    add_str("X:12ab");
    end_line(TERM_LF);
    add_str("X:");
    end_line(TERM_CRLF);
    add_str("X:65535");
    end_line(TERM_LF);
    add_str("X:9");
    send_script(1'b1, 1'b1);
    // more bytes after end of file without a new start
    add_str("X:7");
    end_line(TERM_LF);
    send_script(1'b0, 1'b0);
    wait_drain();
  endtask

  task automatic test_line_edges();
    add_str("  ");
    end_line(TERM_LF);
    end_line(TERM_CR);
    end_line(TERM_LF);
    add_str("W 10 20");                 // second kept char is not a colon
    end_line(TERM_LF);
    script.push_back(8'hFF);
    script.push_back(8'h00);
    script.push_back(8'h7F);
    end_line(TERM_LF);
    // line cut at the length limit, the remainder parsed as its own line
    add_str("X:");
    repeat (410) script.push_back("9");
    end_line(TERM_LF);
    add_str("W:2080");
    for (int i = 0; i < MAX_DATA; i++) add_str($sformatf("%02x", i));
    end_line(TERM_LF);
    add_str("C:44F0");
    for (int i = 0; i < MAX_DATA + 3; i++) add_str($sformatf("%02X", 255 - i));
    end_line(TERM_LF);
    add_str("C:112233");                // cut short by a new file start
    send_script(1'b1, 1'b0);
    wait_drain();
  endtask

  task automatic test_stop();
    add_str("Q:1");
    end_line(TERM_LF);
    add_str("W:102030");                // ignored after the stop
    end_line(TERM_LF);
    send_script(1'b1, 1'b1);
    add_str("w:");
    end_line(TERM_LF);
    add_str("X:3");
    end_line(TERM_LF);
    send_script(1'b1, 1'b0);
    script.push_back(8'h00);
    add_str(":");
    end_line(TERM_LF);
    send_script(1'b1, 1'b0);
    add_str("X:5");
    end_line(TERM_LF);
    send_script(1'b1, 1'b0);
    wait_drain();
  endtask

  task automatic test_output_stall();
    fork
      begin
        hold_on <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_on <= 1'b0;
      end
    join_none
    add_str("W:3C00");
    repeat (40) put_hex(8'($urandom));
    end_line(TERM_LF);
    add_str("X:40");
    end_line(TERM_CRLF);
    send_script(1'b1, 1'b0);
    wait_drain();
  endtask

  task automatic test_random_scripts(int unsigned beats);
    int unsigned target, files, lines;
    target = live_beats + beats;
    files = 0;
    while (live_beats < target) begin
      lines = $urandom_range(1, 6);
      for (int unsigned i = 0; i < lines; i++) random_line(i == lines - 1);
      send_script(1'b1, $urandom_range(0, 3) != 0);
      files++;
      // every few files the sender waits for the parser to drain
      if (files % 5 == 0) wait_drain();
    end
    wait_drain();
  endtask

  initial begin
    clear_line();
    halted = 1'b0;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    test_write_compare();
    test_read_delay();
    test_line_edges();
    test_stop();
    test_output_stall();
    test_random_scripts(RANDOM_BEATS);
    quiet = 1'b1;
    test_random_scripts(TAIL_BEATS);
    wait_drain();
    repeat (SETTLE) @(posedge clk);
    if (errors == 0) begin
      $display("flash_stream_script_parser_unit test passed");
    end else begin
      $display("flash_stream_script_parser_unit test failed");
    end
    $finish;
  end

endmodule

@@ flash_stream_script_parser_unit.f @@
hdl/fssp_pkg.sv
hdl/fssp_core.sv
hdl/fssp_fifo.sv
hdl/flash_stream_script_parser_unit.sv
tb/testbench.sv
